### rtl/core/tvbq_pkg.sv
// Shared types, codes and helpers for the tagged value byte queue codec.
// Used by the byte FIFO, the get-side value decoder and the top-level sequencer; depends on nothing.
`default_nettype none

package tvbq_pkg;

    // Fixed field widths.
    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int VT_W    = 3;
    localparam int FILL_W  = 12;

    // Default sizes handed down from the top level.
    localparam int DEF_QUEUE_DEPTH = 2048;
    localparam int DEF_LONG_BYTES  = 8;

    // Item mode codes.
    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_GET = 1'b1;

    // Value type codes.
    localparam logic [VT_W-1:0] VTYPE_INT8  = 3'd0;
    localparam logic [VT_W-1:0] VTYPE_INT16 = 3'd1;
    localparam logic [VT_W-1:0] VTYPE_INT32 = 3'd2;
    localparam logic [VT_W-1:0] VTYPE_LONG  = 3'd3;
    localparam logic [VT_W-1:0] VTYPE_LLONG = 3'd4;

    // Requests from the sequencer to the byte FIFO, one byte per cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    // FIFO status; rd_valid marks the cycle in which a popped byte is returned.
    typedef struct packed {
        logic full;
        logic empty;
        logic rd_valid;
    } t_fifo_sts;

    // The tag byte stored ahead of a value of the given type.
    function automatic logic [BYTE_W-1:0] tag_of(input logic [VT_W-1:0] vt);
        tag_of = BYTE_W'(vt) + BYTE_W'(1);
    endfunction

endpackage

`default_nettype wire

### rtl/core/tvbq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module tvbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/tvbq_byte_fifo.sv
// Byte ring FIFO: pointers, fill count and the byte store in a tvbq_ram.
// Depends on tvbq_pkg and tvbq_ram.
`default_nettype none

module tvbq_byte_fifo #(
    parameter int QUEUE_DEPTH = tvbq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tvbq_pkg::t_fifo_ctl               i_ctl,
    input  wire logic [tvbq_pkg::BYTE_W-1:0]       i_wdata,
    output tvbq_pkg::t_fifo_sts                    o_sts,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       o_count,
    output logic [tvbq_pkg::BYTE_W-1:0]            o_rdata
);

    import tvbq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_rd_valid;
    logic              r_rd_under;
    logic              full, empty;
    logic              do_write, do_read;
    logic [BYTE_W-1:0] ram_q;

    assign full     = (r_count == CNT_FULL);
    assign empty    = (r_count == '0);
    assign do_write = i_ctl.push && !full;
    assign do_read  = i_ctl.pop && !empty;

    // Pointer wrap and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_write) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            n_count  = r_count + CNT_W'(1);
        end else if (do_read) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            n_count  = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_count    <= '0;
            r_rd_valid <= 1'b0;
            r_rd_under <= 1'b0;
        end else begin
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_count    <= n_count;
            r_rd_valid <= i_ctl.pop;
            r_rd_under <= i_ctl.pop && empty;
        end
    end

    // Byte store.
    tvbq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_wdata),
        .i_re    (do_read),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    // A pop from an empty queue returns a zero byte.
    assign o_rdata        = r_rd_under ? '0 : ram_q;
    assign o_count        = r_count;
    assign o_sts.full     = full;
    assign o_sts.empty    = empty;
    assign o_sts.rd_valid = r_rd_valid;

endmodule

`default_nettype wire

### rtl/core/tvbq_unpack.sv
// Get-side byte collector and value decoder: shifts returned bytes in one per
// cycle and aligns, extends or negates the result. Depends on tvbq_pkg.
`default_nettype none

module tvbq_unpack #(
    parameter int LONG_BYTES = tvbq_pkg::DEF_LONG_BYTES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_rd_valid,
    input  wire logic [tvbq_pkg::BYTE_W-1:0]   i_rdata,
    input  wire logic [tvbq_pkg::VT_W-1:0]     i_value_type,
    output logic [tvbq_pkg::VALUE_W-1:0]       o_value,
    output logic                               o_tag_mismatch
);

    import tvbq_pkg::*;

    localparam int LONG_SHIFT = VALUE_W - BYTE_W * LONG_BYTES;

    logic               r_tag_seen;
    logic [BYTE_W-1:0]  r_tag;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] mag32;

    // The first returned byte is the tag; later bytes enter at the top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_seen <= 1'b0;
        end else if (i_start) begin
            r_tag_seen <= 1'b0;
        end else if (i_rd_valid) begin
            r_tag_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_valid) begin
            if (!r_tag_seen) begin
                r_tag <= i_rdata;
            end else begin
                r_acc <= {i_rdata, r_acc[VALUE_W-1:BYTE_W]};
            end
        end
    end

    // The last bytes read sit at the top of the accumulator.
    assign mag32 = {33'b0, r_acc[VALUE_W-2:VALUE_W-32]};

    always_comb begin
        case (i_value_type)
            VTYPE_INT8: begin
                o_value = {56'b0, r_acc[VALUE_W-1:VALUE_W-8]};
            end
            VTYPE_INT16: begin
                o_value = VALUE_W'($signed(r_acc) >>> (VALUE_W - 16));
            end
            VTYPE_INT32: begin
                o_value = r_acc[VALUE_W-1] ? (VALUE_W'(0) - mag32) : mag32;
            end
            VTYPE_LONG, VTYPE_LLONG: begin
                o_value = VALUE_W'($signed(r_acc) >>> LONG_SHIFT);
            end
            default: begin
                o_value = '0;
            end
        endcase
    end

    assign o_tag_mismatch = (r_tag != tag_of(i_value_type));

endmodule

`default_nettype wire

### rtl/core/tagged_value_byte_queue_codec_core.sv
// Tagged value byte queue codec. A put beat writes a type tag byte and then the
// value's bytes least significant first (1, 2, 4 or LONG_BYTES bytes; int32 is
// sign-magnitude); a get beat reads a tag and decodes the requested type. The
// queue moves one byte per cycle through the byte store; a get adds a drain
// state after its last request to cover the store's registered read. Items are
// worked one at a time; the next one is taken while the previous result still
// waits in the output register. Full puts drop bytes and raise overflowed;
// empty gets read zeros and raise underflowed. The byte store needs no
// initialization after reset.
// Depends on tvbq_pkg, tvbq_byte_fifo, tvbq_unpack and tvbq_ram.
`default_nettype none

module tagged_value_byte_queue_codec_core #(
    parameter int QUEUE_DEPTH = tvbq_pkg::DEF_QUEUE_DEPTH,
    parameter int LONG_BYTES  = tvbq_pkg::DEF_LONG_BYTES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input channel.
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_mode,
    input  wire logic [tvbq_pkg::VT_W-1:0]        i_value_type,
    input  wire logic signed [tvbq_pkg::VALUE_W-1:0] i_put_value,
    // Output channel.
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic signed [tvbq_pkg::VALUE_W-1:0]   o_got_value,
    output logic                                  o_overflowed,
    output logic                                  o_underflowed,
    output logic                                  o_tag_mismatch,
    output logic [tvbq_pkg::FILL_W-1:0]           o_fill_level
);

    import tvbq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]         r_state, n_state;
    logic               r_mode;
    logic [VT_W-1:0]    r_vt;
    logic               r_known;
    logic [3:0]         r_nbytes;
    logic [3:0]         r_step;
    logic [VALUE_W-1:0] r_shift;
    logic               r_over;
    logic               r_under;
    logic               r_out_valid;

    t_fifo_ctl          fifo_ctl;
    t_fifo_sts          fifo_sts;
    logic [BYTE_W-1:0]  fifo_wdata;
    logic [BYTE_W-1:0]  fifo_rdata;
    logic [CNT_W-1:0]   fifo_count;
    logic [VALUE_W-1:0] dec_value;
    logic               dec_mismatch;

    logic               accept;
    logic               load_out;
    logic               known_in;
    logic [3:0]         nbytes_in;
    logic [31:0]        w32;
    logic [31:0]        mag32;
    logic [VALUE_W-1:0] shift_in;

    // Handshake.
    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && (r_state == ST_IDLE);
    assign load_out = (r_state == ST_FIN) && (!r_out_valid || !i_stall);

    // Byte count of the value for the incoming type.
    always_comb begin
        known_in = 1'b1;
        case (i_value_type)
            VTYPE_INT8:               nbytes_in = 4'd1;
            VTYPE_INT16:              nbytes_in = 4'd2;
            VTYPE_INT32:              nbytes_in = 4'd4;
            VTYPE_LONG, VTYPE_LLONG:  nbytes_in = 4'(LONG_BYTES);
            default: begin
                nbytes_in = 4'd0;
                known_in  = 1'b0;
            end
        endcase
    end

    // Int32 is sent as magnitude with the sign in bit 7 of the top byte.
    assign w32   = i_put_value[31:0];
    assign mag32 = w32[31] ? (32'd0 - w32) : w32;
    assign shift_in = (i_value_type == VTYPE_INT32)
                    ? {32'b0, w32[31], mag32[30:0]}
                    : i_put_value;

    // One byte request per cycle while running.
    assign fifo_ctl.push = (r_state == ST_RUN) && (r_mode == MODE_PUT);
    assign fifo_ctl.pop  = (r_state == ST_RUN) && (r_mode == MODE_GET);
    assign fifo_wdata    = (r_step == 4'd0) ? tag_of(r_vt) : r_shift[BYTE_W-1:0];

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = known_in ? ST_RUN : ST_FIN;
                end
            end
            ST_RUN: begin
                if (r_step == r_nbytes) begin
                    n_state = (r_mode == MODE_PUT) ? ST_FIN : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 4'd0;
            r_over      <= 1'b0;
            r_under     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_step  <= 4'd0;
                r_over  <= 1'b0;
                r_under <= 1'b0;
            end else if (r_state == ST_RUN) begin
                r_step  <= r_step + 4'd1;
                r_over  <= r_over || (fifo_ctl.push && fifo_sts.full);
                r_under <= r_under || (fifo_ctl.pop && fifo_sts.empty);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item registers and the put-side shift register, one byte out per cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_vt     <= i_value_type;
            r_known  <= known_in;
            r_nbytes <= nbytes_in;
            r_shift  <= shift_in;
        end else if (fifo_ctl.push && (r_step != 4'd0)) begin
            r_shift  <= {{BYTE_W{1'b0}}, r_shift[VALUE_W-1:BYTE_W]};
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_got_value    <= (r_known && r_mode == MODE_GET) ? dec_value : '0;
            o_overflowed   <= r_over;
            o_underflowed  <= r_under;
            o_tag_mismatch <= r_known && (r_mode == MODE_GET) && dec_mismatch;
            o_fill_level   <= FILL_W'(fifo_count);
        end
    end

    assign o_valid = r_out_valid;

    tvbq_byte_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .i_wdata (fifo_wdata),
        .o_sts   (fifo_sts),
        .o_count (fifo_count),
        .o_rdata (fifo_rdata)
    );

    tvbq_unpack #(
        .LONG_BYTES (LONG_BYTES)
    ) u_unpack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (accept),
        .i_rd_valid     (fifo_sts.rd_valid),
        .i_rdata        (fifo_rdata),
        .i_value_type   (r_vt),
        .o_value        (dec_value),
        .o_tag_mismatch (dec_mismatch)
    );

    // The queue is never reported full and empty at once.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_sts.full && fifo_sts.empty))
        else $error("byte FIFO reports full and empty together");

    // The fill count never passes the queue depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= CNT_W'(QUEUE_DEPTH))
        else $error("byte FIFO count exceeds depth");

    // Returned bytes only arrive while a get item is in flight.
    a_rd_in_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_sts.rd_valid |-> (r_mode == MODE_GET) &&
                              (r_state == ST_RUN || r_state == ST_DRAIN))
        else $error("byte returned outside a get item");

    // A put item leaves the queue at least as full as it found it.
    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_ctl.push |=> fifo_count >= $past(fifo_count))
        else $error("byte count dropped during a put");

endmodule

`default_nettype wire

### tb/tvbq_codec_checker.sv
// Checker for the tagged value byte queue codec: watches both channels, keeps its own
// model of the byte ring and the value codec, and compares every result beat.
// Depends on tvbq_pkg for field widths, mode and value type codes and default sizes.

module tvbq_codec_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel as seen at the block.
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_mode,
    input  logic [tvbq_pkg::VT_W-1:0]         i_value_type,
    input  logic [tvbq_pkg::VALUE_W-1:0]      i_put_value,
    // Output channel as seen at the block.
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [tvbq_pkg::VALUE_W-1:0]      i_got_value,
    input  logic                              i_overflowed,
    input  logic                              i_underflowed,
    input  logic                              i_tag_mismatch,
    input  logic [tvbq_pkg::FILL_W-1:0]       i_fill_level,
    // Status for the stimulus side.
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tvbq_pkg::*;

    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [VALUE_W-1:0] got_value;
        logic               overflowed;
        logic               underflowed;
        logic               tag_mismatch;
        logic [FILL_W-1:0]  fill_level;
    } t_codec_result;

    // Shadow copy of the byte ring.
    logic [BYTE_W-1:0] ring_bytes [DEF_QUEUE_DEPTH];
    int                ring_rd;
    int                ring_wr;
    int                ring_held;
    logic              saw_full;
    logic              saw_empty;

    // Results predicted for accepted beats, oldest first.
    t_codec_result     codec_expected [$];
    int                mismatches  = 0;
    int                result_idx  = 0;

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED) begin
            $display("[%0t] result %0d mismatch: %s", $realtime, result_idx, what);
        end
        mismatches++;
    endtask

    // A byte that finds the ring full is dropped and noted.
    function automatic void push_ring_byte(input logic [BYTE_W-1:0] b);
        if (ring_held >= DEF_QUEUE_DEPTH) begin
            saw_full = 1'b1;
        end else begin
            ring_bytes[ring_wr] = b;
            ring_wr = (ring_wr + 1) % DEF_QUEUE_DEPTH;
            ring_held++;
        end
    endfunction

    // Reading an empty ring yields zero and leaves the pointers alone.
    function automatic logic [BYTE_W-1:0] pop_ring_byte();
        logic [BYTE_W-1:0] b;
        if (ring_held == 0) begin
            saw_empty = 1'b1;
            b = '0;
        end else begin
            b = ring_bytes[ring_rd];
            ring_rd = (ring_rd + 1) % DEF_QUEUE_DEPTH;
            ring_held--;
        end
        return b;
    endfunction

    // Encodes or decodes one beat against the shadow ring and returns its result.
    function automatic t_codec_result predict_codec_result(
        input logic               mode,
        input logic [VT_W-1:0]    vt,
        input logic [VALUE_W-1:0] pv
    );
        t_codec_result      r;
        logic [BYTE_W-1:0]  tag;
        logic [31:0]        word;
        logic [31:0]        mag32;
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] mag;
        r         = '0;
        acc       = '0;
        saw_full  = 1'b0;
        saw_empty = 1'b0;
        tag       = {5'd0, vt} + 8'd1;
        if (vt <= VTYPE_LLONG) begin
            if (mode == MODE_PUT) begin
                push_ring_byte(tag);
                case (vt)
                    VTYPE_INT8: begin
                        push_ring_byte(pv[7:0]);
                    end
                    VTYPE_INT16: begin
                        for (int i = 0; i < 2; i++) push_ring_byte(pv[8*i +: 8]);
                    end
                    VTYPE_INT32: begin
                        // Sign-magnitude: 31 magnitude bits, sign in bit 7 of the top byte.
                        word  = pv[31:0];
                        mag32 = word[31] ? (32'd0 - word) : word;
                        for (int i = 0; i < 3; i++) push_ring_byte(mag32[8*i +: 8]);
                        push_ring_byte({word[31], mag32[30:24]});
                    end
                    default: begin
                        for (int i = 0; i < DEF_LONG_BYTES; i++) push_ring_byte(pv[8*i +: 8]);
                    end
                endcase
            end else begin
                r.tag_mismatch = (pop_ring_byte() != tag);
                case (vt)
                    VTYPE_INT8: begin
                        r.got_value = {56'd0, pop_ring_byte()};
                    end
                    VTYPE_INT16: begin
                        for (int i = 0; i < 2; i++) acc[8*i +: 8] = pop_ring_byte();
                        r.got_value = {{48{acc[15]}}, acc[15:0]};
                    end
                    VTYPE_INT32: begin
                        for (int i = 0; i < 4; i++) acc[8*i +: 8] = pop_ring_byte();
                        mag = {33'd0, acc[30:0]};
                        r.got_value = acc[31] ? (64'd0 - mag) : mag;
                    end
                    default: begin
                        for (int i = 0; i < DEF_LONG_BYTES; i++) acc[8*i +: 8] = pop_ring_byte();
                        if (DEF_LONG_BYTES < 8 && acc[8*DEF_LONG_BYTES-1]) begin
                            acc = acc | (~64'd0 << (8 * DEF_LONG_BYTES));
                        end
                        r.got_value = acc;
                    end
                endcase
            end
        end
        r.overflowed  = saw_full;
        r.underflowed = saw_empty;
        r.fill_level  = FILL_W'(ring_held);
        return r;
    endfunction

    // Result beats are checked before the input beat of the same edge is predicted.
    always @(posedge i_clk) begin : monitor
        t_codec_result want;
        if (!i_rst_n) begin
            ring_rd    = 0;
            ring_wr    = 0;
            ring_held  = 0;
            result_idx = 0;
            codec_expected.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (codec_expected.size() == 0) begin
                    report_mismatch("result beat with no input beat outstanding");
                end else begin
                    want = codec_expected.pop_front();
                    if (i_got_value !== want.got_value) begin
                        report_mismatch($sformatf("got_value %h, expected %h",
                                                  i_got_value, want.got_value));
                    end
                    if (i_overflowed !== want.overflowed) begin
                        report_mismatch($sformatf("overflowed %b, expected %b",
                                                  i_overflowed, want.overflowed));
                    end
                    if (i_underflowed !== want.underflowed) begin
                        report_mismatch($sformatf("underflowed %b, expected %b",
                                                  i_underflowed, want.underflowed));
                    end
                    if (i_tag_mismatch !== want.tag_mismatch) begin
                        report_mismatch($sformatf("tag_mismatch %b, expected %b",
                                                  i_tag_mismatch, want.tag_mismatch));
                    end
                    if (i_fill_level !== want.fill_level) begin
                        report_mismatch($sformatf("fill_level %0d, expected %0d",
                                                  i_fill_level, want.fill_level));
                    end
                end
                result_idx++;
            end
            if (i_in_valid && !i_in_stall) begin
                codec_expected.push_back(
                    predict_codec_result(i_mode, i_value_type, i_put_value));
            end
        end
        o_pending    <= codec_expected.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb.sv
// Top of the codec testbench: clock, reset, stimulus on the input channel, stall
// pattern on the output channel and the final verdict.
// Depends on tvbq_pkg, the codec core and tvbq_codec_checker.

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tvbq_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int MAX_GAP      = 30;
    localparam logic [VT_W-1:0] FIRST_BAD_TYPE = VTYPE_LLONG + 3'd1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_mode;
    logic [VT_W-1:0]      i_value_type;
    logic signed [VALUE_W-1:0] i_put_value;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [VALUE_W-1:0] o_got_value;
    logic                 o_overflowed;
    logic                 o_underflowed;
    logic                 o_tag_mismatch;
    logic [FILL_W-1:0]    o_fill_level;

    int                   fail_count;
    int                   results_pending;

    // Knobs shared by the sender and the stall process.
    int                   tx_idle_pct  = 0;
    int                   rx_stall_pct = 0;
    bit                   hold_req     = 1'b0;

    // Rough view of what sits in the ring, used to pick matching get types.
    logic [VT_W-1:0]      queued_types [$];
    int                   est_bytes = 0;
    int                   put_beats = 0;
    int                   get_beats = 0;
    int                   bad_beats = 0;

    always #5 i_clk = ~i_clk;

    tagged_value_byte_queue_codec_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_value_type   (i_value_type),
        .i_put_value    (i_put_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_got_value    (o_got_value),
        .o_overflowed   (o_overflowed),
        .o_underflowed  (o_underflowed),
        .o_tag_mismatch (o_tag_mismatch),
        .o_fill_level   (o_fill_level)
    );

    tvbq_codec_checker checker_u (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_mode         (i_mode),
        .i_value_type   (i_value_type),
        .i_put_value    (i_put_value),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_got_value    (o_got_value),
        .i_overflowed   (o_overflowed),
        .i_underflowed  (o_underflowed),
        .i_tag_mismatch (o_tag_mismatch),
        .i_fill_level   (o_fill_level),
        .o_fail_count   (fail_count),
        .o_pending      (results_pending)
    );

    // Output stall pattern; a requested hold keeps stall high for a long stretch once.
    initial begin
        bit held;
        held = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Offers one beat after a random gap and returns at the edge that accepts it.
    task automatic send_beat(input logic mode, input logic [VT_W-1:0] vt,
                             input logic [VALUE_W-1:0] pv);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_value_type <= vt;
        i_put_value  <= pv;
        do @(posedge i_clk); while (o_stall);
        if (vt >= FIRST_BAD_TYPE) bad_beats++;
        else if (mode == MODE_PUT) put_beats++;
        else get_beats++;
    endtask

    // Lowers valid and waits until every predicted result has come back.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    // One random beat; gets mostly ask for the type that sits at the head of the ring.
    task automatic random_beat(input int put_pct, input int long_pct);
        logic               mode;
        logic [VT_W-1:0]    vt;
        logic [VALUE_W-1:0] pv;
        int                 nb;
        mode = ($urandom_range(99) < put_pct) ? MODE_PUT : MODE_GET;
        if ($urandom_range(99) < 4) begin
            vt = VT_W'($urandom_range(7, FIRST_BAD_TYPE));
        end else if (mode == MODE_GET && queued_types.size() > 0 &&
                     $urandom_range(99) < 85) begin
            vt = queued_types[0];
        end else if ($urandom_range(99) < long_pct) begin
            vt = $urandom_range(1) ? VTYPE_LONG : VTYPE_LLONG;
        end else begin
            vt = VT_W'($urandom_range(VTYPE_LLONG));
        end
        case ($urandom_range(15))
            0:       pv = '0;
            1:       pv = '1;
            2:       pv = 64'h8000_0000_0000_0000;
            3:       pv = 64'h7FFF_FFFF_FFFF_FFFF;
            4:       pv = 64'hFFFF_FFFF_8000_0000;
            5:       pv = 64'h0000_0000_7FFF_FFFF;
            6:       pv = 64'hFFFF_FFFF_FFFF_8000;
            default: pv = {$urandom(), $urandom()};
        endcase
        if (vt <= VTYPE_LLONG) begin
            case (vt)
                VTYPE_INT8:  nb = 2;
                VTYPE_INT16: nb = 3;
                VTYPE_INT32: nb = 5;
                default:     nb = 1 + DEF_LONG_BYTES;
            endcase
            if (mode == MODE_PUT) begin
                if (est_bytes + nb <= DEF_QUEUE_DEPTH) queued_types.push_back(vt);
                est_bytes = (est_bytes + nb > DEF_QUEUE_DEPTH) ? DEF_QUEUE_DEPTH
                                                               : est_bytes + nb;
            end else begin
                if (queued_types.size() > 0) void'(queued_types.pop_front());
                est_bytes = (est_bytes > nb) ? est_bytes - nb : 0;
            end
        end
        send_beat(mode, vt, pv);
    endtask

    task automatic random_phase(input int beats, input int put_pct, input int long_pct);
        for (int n = 0; n < beats; n++) random_beat(put_pct, long_pct);
    endtask

    // Run limit in case the block hangs.
    initial begin
        #RUN_LIMIT_NS;
        $display("tagged_value_byte_queue_codec_core test failed");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_mode       <= MODE_PUT;
        i_value_type <= VTYPE_INT8;
        i_put_value  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: empty read, each type at its extremes, mismatches, bad types.
        send_beat(MODE_GET, VTYPE_LLONG, '0);
        send_beat(MODE_PUT, VTYPE_INT8, '1);
        send_beat(MODE_GET, VTYPE_INT8, '0);
        send_beat(MODE_PUT, VTYPE_INT16, 64'hFFFF_FFFF_FFFF_8000);
        send_beat(MODE_PUT, VTYPE_INT16, 64'h0000_0000_0000_7FFF);
        send_beat(MODE_GET, VTYPE_INT16, '0);
        send_beat(MODE_GET, VTYPE_INT16, '0);
        // The most negative int32 has no 31-bit magnitude and comes back as zero.
        send_beat(MODE_PUT, VTYPE_INT32, 64'hFFFF_FFFF_8000_0000);
        send_beat(MODE_GET, VTYPE_INT32, '1);
        send_beat(MODE_PUT, VTYPE_INT32, '1);
        send_beat(MODE_PUT, VTYPE_INT32, 64'h0000_0000_7FFF_FFFF);
        send_beat(MODE_GET, VTYPE_INT32, '0);
        send_beat(MODE_GET, VTYPE_INT32, '0);
        send_beat(MODE_PUT, VTYPE_LONG, 64'h8000_0000_0000_0000);
        send_beat(MODE_PUT, VTYPE_LLONG, 64'h7FFF_FFFF_FFFF_FFFF);
        send_beat(MODE_GET, VTYPE_LONG, '0);
        send_beat(MODE_GET, VTYPE_LLONG, '0);
        // Wrong type requested, and the read runs past the end of the ring.
        send_beat(MODE_PUT, VTYPE_INT8, 64'h0000_0000_0000_0005);
        send_beat(MODE_GET, VTYPE_INT16, '0);
        send_beat(MODE_PUT, FIRST_BAD_TYPE, '1);
        send_beat(MODE_GET, FIRST_BAD_TYPE + 3'd1, '0);
        send_beat(MODE_PUT, FIRST_BAD_TYPE + 3'd2, 64'h0123_4567_89AB_CDEF);
        send_beat(MODE_PUT, VTYPE_LLONG, '1);
        send_beat(MODE_GET, VTYPE_INT32, '0);
        send_beat(MODE_GET, VTYPE_INT8, '0);
        send_beat(MODE_GET, VTYPE_LONG, '0);
        wait_results_drained();

        // No idling, opened by a long output hold while beats keep coming.
        hold_req = 1'b1;
        random_phase(150, 55, 30);
        wait_results_drained();

        // Sender idles often; puts dominate so the ring fills and overflows.
        tx_idle_pct = 58;
        random_phase(300, 95, 85);
        wait_results_drained();

        // Receiver stalls often; gets dominate so the ring drains and underflows.
        tx_idle_pct  = 0;
        rx_stall_pct = 58;
        random_phase(300, 5, 30);

        // Both sides idle now and then.
        tx_idle_pct  = 25;
        rx_stall_pct = 25;
        random_phase(200, 50, 30);

        wait_results_drained();
        repeat (30) @(posedge i_clk);

        $display("Covered %0d puts, %0d gets and %0d beats of unknown type over four idle",
                 put_beats, get_beats, bad_beats);
        $display("and stall mixes, with a long output hold, a fill past full and a drain past empty.");
        if (fail_count == 0 && results_pending == 0) begin
            $display("tagged_value_byte_queue_codec_core test passed");
        end else begin
            $display("tagged_value_byte_queue_codec_core test failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/tvbq_pkg.sv
rtl/core/tvbq_ram.sv
rtl/core/tvbq_byte_fifo.sv
rtl/core/tvbq_unpack.sv
rtl/core/tagged_value_byte_queue_codec_core.sv
tb/tvbq_codec_checker.sv
tb/tb.sv
